// ===== rtl/vn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types for the 3D vector normalizer: beat payloads and cell buses.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int unsigned CompW = 32;
  localparam int unsigned TolW  = 31;
  localparam int unsigned SumW  = 64;
  localparam int unsigned RootW = 32;
  localparam int unsigned RemW  = 34;
  localparam logic [TolW-1:0] TolReset = 31'd7;

  typedef struct packed {
    logic signed [CompW-1:0] comp_x;
    logic signed [CompW-1:0] comp_y;
    logic signed [CompW-1:0] comp_z;
  } vec_t;

  typedef struct packed {
    logic signed [CompW-1:0] unit_x;
    logic signed [CompW-1:0] unit_y;
    logic signed [CompW-1:0] unit_z;
    logic                    degenerate;
  } res_t;

  // bus between square-root cells
  typedef struct packed {
    logic                        valid;
    logic [SumW-1:0]             rad;
    logic [RemW-1:0]             rem;
    logic [RootW-1:0]            root;
    logic [2:0]                  neg;
    logic [2:0][CompW-1:0]       mag;
  } sq_t;

  // bus between divider cells (quotient bits travel separately)
  typedef struct packed {
    logic                        valid;
    logic                        degen;
    logic [RootW-1:0]            dvsr;
    logic [2:0]                  neg;
    logic [2:0][CompW-1:0]       mag;
    logic [2:0][RootW-1:0]       rem;
  } dv_t;

endpackage

// ===== rtl/vector3_normalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize
// Q-format 3D vector normalizer: square-root cell row, then divider cell row.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// command   in         start / busy (busy=0)     vec_i   (vn_pkg::vec_t)
// result    out        res_valid_o strobe        res_o   (vn_pkg::res_t)
// config    in         cfg_valid_i / cfg_ready_o cfg_data_i (tolerance)
//
// One beat accepted every cycle; busy is never raised.
// The result strobe comes out of FRAC_BITS + 37 register stages: 2 prep stages
// (abs, squares; the sum feeds the first root cell), 32 square-root cells, one
// degenerate check, FRAC_BITS+1 divider cells and one output stage. Reset empties
// the pipe; tolerance resets to 7.
// The receiver cannot stall, so nothing holds a beat in the pipe.
// ----------------------------------------------------------------------------
module vector3_normalize #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  vn_pkg::vec_t                  vec_i,
  output logic                          res_valid_o,
  output vn_pkg::res_t                  res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vn_pkg::TolW-1:0]       cfg_data_i
);

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned CW = vn_pkg::CompW;

  logic [vn_pkg::TolW-1:0] tol_q;

  // prep stages
  logic             v0_q, v1_q;
  logic [2:0]       neg0_q, neg1_q;
  logic [2:0][CW-1:0] mag0_q, mag1_q;
  logic [2:0][2*CW-1:0] sqr_q;
  logic signed [CW-1:0] comp [3];

  vn_pkg::sq_t sq [vn_pkg::RootW+1];
  vn_pkg::dv_t dv [QW+1];
  logic [2:0][QW-1:0] quo [QW+1];

  vn_pkg::dv_t prep_d, prep_q;

  logic             out_valid_q;
  vn_pkg::res_t     res_d, res_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= vn_pkg::TolReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  assign comp[0] = vec_i.comp_x;
  assign comp[1] = vec_i.comp_y;
  assign comp[2] = vec_i.comp_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      neg0_q[l] <= comp[l][CW-1];
      mag0_q[l] <= comp[l][CW-1] ? (CW'(0) - CW'(comp[l])) : CW'(comp[l]);
      sqr_q[l]  <= (2*CW)'(mag0_q[l]) * (2*CW)'(mag0_q[l]);
    end
    neg1_q <= neg0_q;
    mag1_q <= mag0_q;
  end

  // sum of squares fits 64 bits since each square is at most 2^62
  always_comb begin
    sq[0]       = '0;
    sq[0].valid = v1_q;
    sq[0].rad   = sqr_q[0] + sqr_q[1] + sqr_q[2];
    sq[0].neg   = neg1_q;
    sq[0].mag   = mag1_q;
  end

  for (genvar k = 0; k < vn_pkg::RootW; k++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .a_i   (sq[k]),
      .a_o   (sq[k+1])
    );
  end

  // degenerate check; a zero divisor only occurs on the degenerate path
  always_comb begin
    prep_d       = '0;
    prep_d.valid = sq[vn_pkg::RootW].valid;
    prep_d.degen = (sq[vn_pkg::RootW].root <= {1'b0, tol_q});
    prep_d.dvsr  = sq[vn_pkg::RootW].root;
    prep_d.neg   = sq[vn_pkg::RootW].neg;
    prep_d.mag   = sq[vn_pkg::RootW].mag;
    for (int l = 0; l < 3; l++) begin
      prep_d.rem[l] = {1'b0, sq[vn_pkg::RootW].mag[l][CW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
    end else begin
      prep_q <= prep_d;
    end
  end

  assign dv[0]  = prep_q;
  assign quo[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    vn_div_cell #(
      .QW   (QW),
      .FIRST(k == 0)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .a_i   (dv[k]),
      .quo_i (quo[k]),
      .a_o   (dv[k+1]),
      .quo_o (quo[k+1])
    );
  end

  always_comb begin
    logic [CW-1:0] q [3];
    logic [CW-1:0] o [3];
    for (int l = 0; l < 3; l++) begin
      q[l] = dv[QW].degen ? dv[QW].mag[l] : CW'(quo[QW][l]);
      if (q[l] < {1'b0, tol_q}) begin
        q[l] = '0;
      end
      o[l] = dv[QW].neg[l] ? (CW'(0) - q[l]) : q[l];
    end
    res_d.unit_x     = o[0];
    res_d.unit_y     = o[1];
    res_d.unit_z     = o[2];
    res_d.degenerate = dv[QW].degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= dv[QW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/vn_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_sqrt_cell
// One digit of a restoring integer square root; resolves one root bit.
// ----------------------------------------------------------------------------
module vn_sqrt_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vn_pkg::sq_t a_i,
  output vn_pkg::sq_t a_o
);

  logic [vn_pkg::RemW+1:0] shifted;
  logic [vn_pkg::RemW+1:0] trial;
  logic                    ge;
  logic [vn_pkg::RemW+1:0] diff;
  vn_pkg::sq_t             a_d, a_q;

  always_comb begin
    shifted = {a_i.rem, a_i.rad[vn_pkg::SumW-1 -: 2]};
    trial   = {2'b00, a_i.root, 2'b01};
    ge      = (shifted >= trial);
    diff    = shifted - trial;
    a_d      = a_i;
    a_d.rad  = {a_i.rad[vn_pkg::SumW-3:0], 2'b00};
    a_d.rem  = ge ? diff[vn_pkg::RemW-1:0] : shifted[vn_pkg::RemW-1:0];
    a_d.root = {a_i.root[vn_pkg::RootW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else begin
      a_q <= a_d;
    end
  end

  assign a_o = a_q;

endmodule

// ===== rtl/vn_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_div_cell
// One restoring division step on three lanes sharing one divisor.
// ----------------------------------------------------------------------------
module vn_div_cell #(
  parameter int unsigned QW    = 17,
  parameter bit          FIRST = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vn_pkg::dv_t          a_i,
  input  logic [2:0][QW-1:0]   quo_i,
  output vn_pkg::dv_t          a_o,
  output logic [2:0][QW-1:0]   quo_o
);

  vn_pkg::dv_t        a_d, a_q;
  logic [2:0][QW-1:0] quo_d, quo_q;
  logic [vn_pkg::RootW:0] part [3];
  logic [vn_pkg::RootW:0] diff [3];
  logic [2:0]         ge;

  always_comb begin
    a_d = a_i;
    for (int l = 0; l < 3; l++) begin
      // only the lowest magnitude bit can be nonzero among those brought down here
      part[l] = {a_i.rem[l], (FIRST ? a_i.mag[l][0] : 1'b0)};
      diff[l] = part[l] - {1'b0, a_i.dvsr};
      ge[l]   = (part[l] >= {1'b0, a_i.dvsr});
      a_d.rem[l] = ge[l] ? diff[l][vn_pkg::RootW-1:0] : part[l][vn_pkg::RootW-1:0];
      quo_d[l]   = {quo_i[l][QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= '0;
      quo_q <= '0;
    end else begin
      a_q   <= a_d;
      quo_q <= quo_d;
    end
  end

  assign a_o   = a_q;
  assign quo_o = quo_q;

endmodule

// ===== sim/vector3_normalize_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_test
// Self-checking bench for the 3D vector normalizer: vectors go in through the
// start/busy port, each result is checked against an in-bench computation of
// magnitude, division and small-component flush, over several tolerances.
// ----------------------------------------------------------------------------
module vector3_normalize_test;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned Latency   = FracBits + 36;
  localparam int unsigned NumRandom = 480;
  localparam longint      CycleMax  = 400000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  vn_pkg::vec_t            vec_i = '0;
  logic                    res_valid_o;
  vn_pkg::res_t            res_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [vn_pkg::TolW-1:0] cfg_data_i = '0;

  vector3_normalize #(.FRAC_BITS(FracBits)) u_top (
    .clk_i, .rst_ni, .start, .busy, .vec_i, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  vn_pkg::vec_t            pending_vecs[$];
  vn_pkg::res_t            expected_units[$];
  logic [vn_pkg::TolW-1:0] tol_now = vn_pkg::TolReset;
  bit                      quiet_stretch = 1'b0;
  int                      errors = 0;
  longint                  cycles = 0;

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] unit_comp(logic signed [31:0] c, logic [63:0] mag,
                                            bit degen, logic [vn_pkg::TolW-1:0] tol);
    logic [63:0] a;
    logic [63:0] q;
    a = c[31] ? 64'(-64'(c)) : 64'(c);
    q = degen ? a : ((a << FracBits) / mag);
    if (q < 64'(tol)) q = 0;
    return c[31] ? 32'(-q) : q[31:0];
  endfunction

  function automatic vn_pkg::res_t normalize(vn_pkg::vec_t v, logic [vn_pkg::TolW-1:0] tol);
    vn_pkg::res_t r;
    logic [63:0]  sum;
    logic [63:0]  mag;
    logic [63:0]  ax, ay, az;
    bit           degen;
    ax  = v.comp_x[31] ? 64'(-64'(v.comp_x)) : 64'(v.comp_x);
    ay  = v.comp_y[31] ? 64'(-64'(v.comp_y)) : 64'(v.comp_y);
    az  = v.comp_z[31] ? 64'(-64'(v.comp_z)) : 64'(v.comp_z);
    sum = ax * ax + ay * ay + az * az;
    mag = root_floor(sum);
    degen = (mag <= 64'(tol));
    r.unit_x = unit_comp(v.comp_x, mag, degen, tol);
    r.unit_y = unit_comp(v.comp_y, mag, degen, tol);
    r.unit_z = unit_comp(v.comp_z, mag, degen, tol);
    r.degenerate = degen;
    return r;
  endfunction

  // driver: randomly gaps start between beats, but in the quiet stretch keeps start high across back-to-back beats
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_units.push_back(normalize(vec_i, tol_now));
        void'(pending_vecs.pop_front());
      end
      if (pending_vecs.size() != 0 && (quiet_stretch || $urandom_range(99) >= 27)) begin
        start <= 1'b1;
        vec_i <= pending_vecs[0];
      end else begin
        start <= 1'b0;
        vec_i <= vn_pkg::vec_t'({$urandom, $urandom, $urandom});
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    vn_pkg::res_t exp_r;
    cycles <= cycles + 1;
    if (res_valid_o) begin
      if (expected_units.size() == 0) begin
        $error("unexpected result %h", res_o);
        errors = errors + 1;
      end else begin
        exp_r = expected_units.pop_front();
        if (res_o.unit_x !== exp_r.unit_x) begin
          $error("unit_x exp %h got %h", exp_r.unit_x, res_o.unit_x);
          errors = errors + 1;
        end
        if (res_o.unit_y !== exp_r.unit_y) begin
          $error("unit_y exp %h got %h", exp_r.unit_y, res_o.unit_y);
          errors = errors + 1;
        end
        if (res_o.unit_z !== exp_r.unit_z) begin
          $error("unit_z exp %h got %h", exp_r.unit_z, res_o.unit_z);
          errors = errors + 1;
        end
        if (res_o.degenerate !== exp_r.degenerate) begin
          $error("degenerate exp %b got %b", exp_r.degenerate, res_o.degenerate);
          errors = errors + 1;
        end
      end
    end
    if (cycles > CycleMax) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic drain();
    while (pending_vecs.size() != 0 || start || expected_units.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [vn_pkg::TolW-1:0] tol);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= tol;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tol_now = tol;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= vn_pkg::TolW'($urandom);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0:       return $urandom_range(40) - 20;
      1:       return $urandom_range(32'h0003_0000) - 32'h0001_8000;
      2:       return {$urandom_range(1) ? 1'b1 : 1'b0, 31'(0)} | $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    vn_pkg::vec_t v;
    repeat (n) begin
      v.comp_x = rand_comp();
      v.comp_y = rand_comp();
      v.comp_z = rand_comp();
      // one-hot and two-zero vectors hit exact unit results
      if ($urandom_range(7) == 0) begin
        v.comp_y = 0;
        v.comp_z = 0;
      end
      pending_vecs.push_back(v);
    end
  endtask

  initial begin
    logic [vn_pkg::TolW-1:0] tols[6];
    tols = '{31'd0, 31'd1, 31'd100, 31'h0001_0000, 31'h0000_8000, 31'h7FFF_FFFF};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero, extremes, signs, small and degenerate vectors
    pending_vecs.push_back('{0, 0, 0});
    pending_vecs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_vecs.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_vecs.push_back('{32'h8000_0000, 0, 0});
    pending_vecs.push_back('{0, 32'h7FFF_FFFF, 0});
    pending_vecs.push_back('{0, 0, -1});
    pending_vecs.push_back('{1, -1, 1});
    pending_vecs.push_back('{5, 0, -3});
    pending_vecs.push_back('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
    pending_vecs.push_back('{32'h0003_0000, -32'h0004_0000, 0});
    pending_vecs.push_back('{32'h0000_0100, 32'h7000_0000, -7});
    pending_vecs.push_back('{32'hFFFF_FFFF, 32'h8000_0001, 32'h5555_5555});
    pending_vecs.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
    random_phase(60);
    drain();

    foreach (tols[i]) begin
      write_tolerance(tols[i]);
      quiet_stretch = (i == 2);
      random_phase(NumRandom / 6);
      if (i == 4) random_phase(20);
      drain();
    end
    write_tolerance(vn_pkg::TolW'($urandom_range(2000)));
    random_phase(40);
    drain();

    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vn_pkg.sv
rtl/vn_sqrt_cell.sv
rtl/vn_div_cell.sv
rtl/vector3_normalize.sv
sim/vector3_normalize_test.sv
